// File: rtl/core/tlve_pkg.sv
// ----------------------------------------------------------------------------
// TLV target tag extractor package
// Shared result word, queue status bundle, status codes and TLV constants.
// ----------------------------------------------------------------------------
package tlve_pkg;

  // Status codes carried on the result word.
  typedef enum logic [1:0] {
    ST_VALUE     = 2'd0,
    ST_FINAL     = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // One result word as it travels from the parser to the output stage.
  typedef struct packed {
    logic [7:0] value_byte;
    status_e    status;
    logic       last;
  } res_t;

  // Queue status seen by both of its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Depth of the queue between parser and output stage (a power of two).
  localparam int unsigned QueueDepth = 2;

  // BER-TLV encoding constants.
  localparam logic [7:0] TagMultiMask = 8'h1F;
  localparam logic [7:0] LenLongFlag  = 8'h80;
  localparam logic [7:0] LenLong1     = 8'h81;
  localparam logic [7:0] LenLong3     = 8'h83;

  // Width of a decoded element length.
  localparam int unsigned LenAccW = 24;

endpackage

// File: rtl/core/tlve_front.sv
// ----------------------------------------------------------------------------
// TLV extractor parser front
// Walks tag, length and value fields one byte per accepted cycle and forms results.
// ----------------------------------------------------------------------------
module tlve_front #(
  parameter int unsigned BUFFER_LENGTH_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic [15:0]         buffer_length_i,
  input  logic [7:0]          target_tag_i,
  output logic                push_o,
  output tlve_pkg::res_t      push_word_o
);

  localparam int unsigned TotW = (BUFFER_LENGTH_BITS < 16) ? BUFFER_LENGTH_BITS : 16;
  localparam int unsigned PosW = ((BUFFER_LENGTH_BITS > 16) ? BUFFER_LENGTH_BITS : 16) + 1;
  localparam int unsigned CmpW = (PosW > tlve_pkg::LenAccW) ? PosW : tlve_pkg::LenAccW;
  localparam int unsigned AccW = tlve_pkg::LenAccW;

  typedef enum logic [2:0] {
    PH_TAG       = 3'd0,
    PH_TAG_MORE  = 3'd1,
    PH_LEN_FIRST = 3'd2,
    PH_LEN_MORE  = 3'd3,
    PH_SKIP      = 3'd4,
    PH_VALUE     = 3'd5
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [BUFFER_LENGTH_BITS-1:0] pos_q, pos_d;
  logic [AccW-1:0]               acc_q, acc_d;
  logic [1:0]                    left_q, left_d;
  logic [AccW-1:0]               rem_q, rem_d;
  logic                          match_q, match_d;
  logic                          fin_q, fin_d;

  logic [PosW-1:0] total_w;
  logic [PosW-1:0] next_pos;
  logic [PosW-1:0] room;
  logic            at_end;
  logic            len_done;
  logic            not_found;
  logic            res_vld;
  tlve_pkg::res_t  res;

  assign total_w  = PosW'(buffer_length_i[TotW-1:0]);
  assign next_pos = PosW'(pos_q) + PosW'(1);
  assign at_end   = (next_pos >= total_w);
  assign room     = (total_w > next_pos) ? (total_w - next_pos) : '0;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    acc_d     = acc_q;
    left_d    = left_q;
    rem_d     = rem_q;
    match_d   = match_q;
    fin_d     = fin_q;
    len_done  = 1'b0;
    not_found = 1'b0;
    res_vld   = 1'b0;
    res       = '0;

    if (!fin_q) begin
      unique case (phase_q)
        PH_TAG: begin
          match_d = (data_byte_i == target_tag_i);
          phase_d = ((data_byte_i & tlve_pkg::TagMultiMask) == tlve_pkg::TagMultiMask)
                    ? PH_TAG_MORE : PH_LEN_FIRST;
        end
        PH_TAG_MORE: begin
          if (!data_byte_i[7]) begin
            phase_d = PH_LEN_FIRST;
          end
        end
        PH_LEN_FIRST: begin
          if (data_byte_i < tlve_pkg::LenLongFlag) begin
            acc_d    = AccW'(data_byte_i);
            len_done = 1'b1;
          end else if (data_byte_i >= tlve_pkg::LenLong1 &&
                       data_byte_i <= tlve_pkg::LenLong3) begin
            acc_d   = '0;
            left_d  = data_byte_i[1:0];
            phase_d = PH_LEN_MORE;
          end else begin
            not_found = 1'b1;
          end
        end
        PH_LEN_MORE: begin
          acc_d  = {acc_q[AccW-9:0], data_byte_i};
          left_d = left_q - 2'd1;
          if (left_d == 2'd0) begin
            len_done = 1'b1;
          end
        end
        PH_SKIP: begin
          rem_d = rem_q - AccW'(1);
          if (rem_d == '0) begin
            phase_d = PH_TAG;
          end
        end
        PH_VALUE: begin
          rem_d          = rem_q - AccW'(1);
          res.value_byte = data_byte_i;
          res_vld        = 1'b1;
          if (rem_d == '0) begin
            res.status = tlve_pkg::ST_FINAL;
            res.last   = 1'b1;
            fin_d      = 1'b1;
          end else begin
            res.status = tlve_pkg::ST_VALUE;
            res.last   = at_end;
          end
        end
        default: begin
          not_found = 1'b1;
        end
      endcase

      // The length is complete: check it against the room left, then pick
      // between value output, skipping the element, or the next tag; an empty match is not found.
      if (len_done) begin
        if (CmpW'(acc_d) > CmpW'(room)) begin
          not_found = 1'b1;
        end else if (match_q) begin
          if (acc_d == '0) begin
            not_found = 1'b1;
          end else begin
            rem_d   = acc_d;
            phase_d = PH_VALUE;
          end
        end else if (acc_d == '0) begin
          phase_d = PH_TAG;
        end else begin
          rem_d   = acc_d;
          phase_d = PH_SKIP;
        end
      end

      if (!res_vld && (not_found || at_end)) begin
        res.value_byte = '0;
        res.status     = tlve_pkg::ST_NOT_FOUND;
        res.last       = 1'b1;
        res_vld        = 1'b1;
        fin_d          = 1'b1;
      end
    end

    if (at_end) begin
      phase_d = PH_TAG;
      pos_d   = '0;
      acc_d   = '0;
      left_d  = '0;
      rem_d   = '0;
      match_d = 1'b0;
      fin_d   = 1'b0;
    end else begin
      pos_d = next_pos[BUFFER_LENGTH_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      pos_q   <= '0;
      acc_q   <= '0;
      left_q  <= '0;
      rem_q   <= '0;
      match_q <= 1'b0;
      fin_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      rem_q   <= rem_d;
      match_q <= match_d;
      fin_q   <= fin_d;
    end
  end

  assign push_o      = accept_i && res_vld;
  assign push_word_o = res;

endmodule

// File: rtl/core/tlve_queue.sv
// ----------------------------------------------------------------------------
// TLV extractor result queue
// Short register queue that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
module tlve_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tlve_pkg::res_t    push_word_i,
  input  logic              pop_i,
  output tlve_pkg::res_t    pop_word_o,
  output tlve_pkg::q_stat_t stat_o
);

  localparam int unsigned Depth = tlve_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tlve_pkg::res_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  assign pop_word_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("queue count did not follow a write");
`endif

endmodule

// File: rtl/core/tlve_back.sv
// ----------------------------------------------------------------------------
// TLV extractor output stage
// Holds one result word on the output ports until the receiver takes it.
// ----------------------------------------------------------------------------
module tlve_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tlve_pkg::res_t    q_word_i,
  input  tlve_pkg::q_stat_t q_stat_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tlve_pkg::res_t    out_word_o
);

  logic           valid_q;
  tlve_pkg::res_t word_q;

  // Refill whenever the register is empty or its word leaves this cycle.
  assign q_pop_o = !q_stat_i.empty && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      word_q <= q_word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

// File: rtl/core/tlv_target_tag_extractor_top.sv
// ----------------------------------------------------------------------------
// TLV target tag extractor, top level
// Path: a result word is written into the queue at the edge that accepts its
// byte, then moved into the output register that drives the output ports.
// Throughput: one byte per cycle while the queue is not full.
// Reset: asynchronous, active low; parser state and queue empty at once.
// ----------------------------------------------------------------------------
module tlv_target_tag_extractor_top #(
  parameter int unsigned BUFFER_LENGTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel: one buffer byte per word.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] buffer_length_i,
  input  logic [7:0]  target_tag_i,
  // Output channel: value bytes of the match, or one not-found word.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  value_byte_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  // The parser front consumes a byte in the cycle it is accepted and may
  // push one result word into the queue. The queue is the only thing that
  // can hold the input back: when it is full, new bytes are stalled. The
  // output stage drains the queue into a register that faces the receiver,
  // so a stalled receiver never blocks the parser while the queue has room.

  logic              accept;
  logic              push;
  tlve_pkg::res_t    push_word;
  logic              pop;
  tlve_pkg::res_t    pop_word;
  tlve_pkg::q_stat_t q_stat;
  tlve_pkg::res_t    out_word;

  assign in_stall_o = q_stat.full;
  assign accept     = in_valid_i && !in_stall_o;

  tlve_front #(
    .BUFFER_LENGTH_BITS(BUFFER_LENGTH_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .buffer_length_i(buffer_length_i),
    .target_tag_i   (target_tag_i),
    .push_o         (push),
    .push_word_o    (push_word)
  );

  tlve_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_word_i(push_word),
    .pop_i      (pop),
    .pop_word_o (pop_word),
    .stat_o     (q_stat)
  );

  tlve_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_word_i   (pop_word),
    .q_stat_i   (q_stat),
    .q_pop_o    (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word)
  );

  // Unpack the result word onto the output ports.
  assign value_byte_o = out_word.value_byte;
  assign status_o     = out_word.status;
  assign last_o       = out_word.last;

endmodule

// File: tb/sv/tlv_scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV tag extractor scoreboard
// Watches both channels of the extractor. It replays every accepted byte
// through its own copy of the parser, queues the result that the byte should
// cause, and compares each delivered result against the oldest prediction.
// ----------------------------------------------------------------------------
module tlv_scan_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] buffer_length_i,
  input  logic [7:0]  target_tag_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  value_byte_i,
  input  logic [1:0]  status_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef enum logic [2:0] {
    SCAN_TAG,
    SCAN_TAG_EXT,
    SCAN_LEN,
    SCAN_LEN_EXT,
    SCAN_SKIP,
    SCAN_VALUE
  } scan_phase_e;

  scan_phase_e                  phase;
  logic [15:0]                  pos;
  logic [tlve_pkg::LenAccW-1:0] len_acc;
  logic [tlve_pkg::LenAccW-1:0] remaining;
  logic [1:0]                   len_left;
  logic                         is_match;
  logic                         finished;

  tlve_pkg::res_t expected_q[$];
  int             errors;

  assign fail_count_o = errors;
  assign pending_o    = expected_q.size();

  function automatic void clear_scan();
    phase     = SCAN_TAG;
    pos       = '0;
    len_acc   = '0;
    len_left  = '0;
    remaining = '0;
    is_match  = 1'b0;
    finished  = 1'b0;
  endfunction

  // Called once the whole length field is in. Returns 1 when the element
  // ends the search without a match.
  function automatic bit close_length(input logic [16:0] next_pos,
                                      input logic [15:0] total);
    logic [tlve_pkg::LenAccW-1:0] room;
    room = ({1'b0, total} > next_pos) ?
           tlve_pkg::LenAccW'(total) - tlve_pkg::LenAccW'(next_pos) : '0;
    if (len_acc > room) return 1'b1;
    if (is_match) begin
      if (len_acc == '0) return 1'b1;
      remaining = len_acc;
      phase     = SCAN_VALUE;
      return 1'b0;
    end
    if (len_acc == '0) begin
      phase = SCAN_TAG;
    end else begin
      remaining = len_acc;
      phase     = SCAN_SKIP;
    end
    return 1'b0;
  endfunction

  // Advances the parser by one byte. Returns 1 when the byte yields a result.
  function automatic bit scan_byte(input logic [7:0] b, input logic [15:0] total,
                                   input logic [7:0] tag, output tlve_pkg::res_t r);
    logic [16:0] next_pos;
    bit          at_end;
    bit          miss;
    bit          hit;
    next_pos = {1'b0, pos} + 17'd1;
    at_end   = next_pos >= {1'b0, total};
    miss     = 1'b0;
    hit      = 1'b0;
    r        = '0;
    if (!finished) begin
      case (phase)
        SCAN_TAG: begin
          is_match = (b == tag);
          phase = ((b & tlve_pkg::TagMultiMask) == tlve_pkg::TagMultiMask) ?
                  SCAN_TAG_EXT : SCAN_LEN;
        end
        SCAN_TAG_EXT: begin
          if (!b[7]) phase = SCAN_LEN;
        end
        SCAN_LEN: begin
          if (b < tlve_pkg::LenLongFlag) begin
            len_acc = tlve_pkg::LenAccW'(b);
            miss = close_length(next_pos, total);
          end else if (b >= tlve_pkg::LenLong1 && b <= tlve_pkg::LenLong3) begin
            len_acc  = '0;
            len_left = 2'(b - tlve_pkg::LenLongFlag);
            phase    = SCAN_LEN_EXT;
          end else begin
            miss = 1'b1;
          end
        end
        SCAN_LEN_EXT: begin
          len_acc  = {len_acc[tlve_pkg::LenAccW-9:0], b};
          len_left = len_left - 2'd1;
          if (len_left == 2'd0) miss = close_length(next_pos, total);
        end
        SCAN_SKIP: begin
          remaining = remaining - 1'b1;
          if (remaining == '0) phase = SCAN_TAG;
        end
        SCAN_VALUE: begin
          remaining    = remaining - 1'b1;
          r.value_byte = b;
          hit          = 1'b1;
          if (remaining == '0) begin
            r.status = tlve_pkg::ST_FINAL;
            r.last   = 1'b1;
            finished = 1'b1;
          end else begin
            r.status = tlve_pkg::ST_VALUE;
            r.last   = at_end;
          end
        end
        default: miss = 1'b1;
      endcase
      if (!hit && (miss || at_end)) begin
        r.value_byte = '0;
        r.status     = tlve_pkg::ST_NOT_FOUND;
        r.last       = 1'b1;
        finished     = 1'b1;
        hit          = 1'b1;
      end
    end
    if (at_end) clear_scan();
    else pos = next_pos[15:0];
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tlve_pkg::res_t want;
    tlve_pkg::res_t got;
    if (!rst_ni) begin
      clear_scan();
      expected_q.delete();
      errors = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.value_byte = value_byte_i;
        got.status     = tlve_pkg::status_e'(status_i);
        got.last       = last_i;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result value %02h status %0d last %0b", $time,
                   got.value_byte, got.status, got.last);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.value_byte !== want.value_byte) begin
            $display("%0t: value_byte expected %02h actual %02h", $time,
                     want.value_byte, got.value_byte);
            errors++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (scan_byte(data_byte_i, buffer_length_i, target_tag_i, want))
          expected_q.insert(expected_q.size(), want);
      end
    end
  end

endmodule

// File: tb/sv/tb_tlv_target_tag_extractor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV target tag extractor testbench
// Streams BER-TLV buffers into the extractor one byte per word: a handful of
// hand-built buffers for the corner cases, then random buffers that are
// mostly well formed with random content, plus noise, truncated buffers and
// buffers whose length shrinks midway. Both sides idle at random. A separate
// scoreboard predicts and checks every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_tlv_target_tag_extractor_top;

  localparam int          RandomWords = 1950;
  // Worst case is roughly 2k words; leave a wide margin.
  localparam int          CycleLimit  = 400000;
  localparam logic [7:0]  LenLong2    = tlve_pkg::LenLong1 + 8'd1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic [15:0] buffer_length = '0;
  logic [7:0]  target_tag = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  value_byte;
  logic [1:0]  status;
  logic        last;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          words_sent = 0;
  bit          sender_quiet = 1'b0;
  bit          taker_quiet = 1'b0;
  int          stall_left = 0;

  // The buffer being built: its bytes and the length sent with each byte.
  logic [7:0]  frame_q[$];
  logic [15:0] span_q[$];

  // 20 ns clock period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  tlv_target_tag_extractor_top #(
    .BUFFER_LENGTH_BITS(16)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_byte_i     (data_byte),
    .buffer_length_i (buffer_length),
    .target_tag_i    (target_tag),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .value_byte_o    (value_byte),
    .status_o        (status),
    .last_o          (last)
  );

  tlv_scan_checker u_scan_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .data_byte_i     (data_byte),
    .buffer_length_i (buffer_length),
    .target_tag_i    (target_tag),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .value_byte_i    (value_byte),
    .status_i        (status),
    .last_i          (last),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Hard stop in case the block hangs or drops results.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side: after every accepted result, the receiver may stall at random. Now and
  // then the receiver switches into a quiet mode in which it never stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    int draw;
    if (!rst_ni) begin
      out_stall   <= 1'b0;
      stall_left  <= 0;
      taker_quiet <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if ($urandom_range(0, 59) == 0) taker_quiet <= !taker_quiet;
      draw = taker_quiet ? 0 : $urandom_range(0, 7);
      stall_left <= draw;
      out_stall  <= (draw != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // Offers one word after a random gap and returns at the edge that takes it.
  // Valid is only lowered when a gap is actually inserted, so a back-to-back
  // word never sees valid dropped and raised within one time step.
  task automatic send_word(input logic [7:0] b, input logic [15:0] span,
                           input logic [7:0] tag);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    buffer_length <= span;
    target_tag    <= tag;
    do @(posedge clk_i); while (in_stall);
    words_sent++;
  endtask

  task automatic play_frame(input logic [7:0] tag);
    foreach (frame_q[i]) send_word(frame_q[i], span_q[i], tag);
    frame_q.delete();
    span_q.delete();
  endtask

  // Holds the input off until the scoreboard has seen every predicted result.
  // The extra edge lets the prediction for the last word land first.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Appends one byte to the buffer being built.
  function automatic void add_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endfunction

  // Appends the length that goes with the next byte of the buffer.
  function automatic void add_span(input logic [15:0] span);
    span_q.insert(span_q.size(), span);
  endfunction

  function automatic void put(input logic [7:0] b, input logic [15:0] span);
    add_byte(b);
    add_span(span);
  endfunction

  // A first tag byte with the low five bits set opens a multi-byte tag: add
  // up to two continuation bytes with bit 7 set and one closing byte.
  function automatic void append_tag(input logic [7:0] first);
    add_byte(first);
    if ((first & tlve_pkg::TagMultiMask) == tlve_pkg::TagMultiMask) begin
      repeat ($urandom_range(0, 2)) add_byte(8'($urandom) | 8'h80);
      add_byte(8'($urandom) & 8'h7F);
    end
  endfunction

  // Encodes a length in a randomly chosen form, including long forms with
  // leading zero bytes. Rarely writes an illegal first length byte instead.
  function automatic void append_length(input int n);
    int form;
    if ($urandom_range(0, 33) == 0) begin
      add_byte($urandom_range(0, 1) ? tlve_pkg::LenLongFlag : 8'($urandom_range(132, 255)));
      return;
    end
    form = $urandom_range(0, 3);
    if (n < 128 && form == 0) begin
      add_byte(8'(n));
    end else if (n < 256 && form <= 1) begin
      add_byte(tlve_pkg::LenLong1);
      add_byte(8'(n));
    end else if (n < 65536 && form <= 2) begin
      add_byte(LenLong2);
      add_byte(8'(n >> 8));
      add_byte(8'(n));
    end else begin
      add_byte(tlve_pkg::LenLong3);
      add_byte(8'(n >> 16));
      add_byte(8'(n >> 8));
      add_byte(8'(n));
    end
  endfunction

  function automatic void append_element(input logic [7:0] tag, input int n);
    append_tag(tag);
    append_length(n);
    repeat (n) add_byte(8'($urandom));
  endfunction

  // Element sizes stay small; a few exceed 127 to need a long length form.
  function automatic int draw_size();
    if ($urandom_range(0, 49) == 0) return $urandom_range(128, 300);
    return $urandom_range(0, 6);
  endfunction

  // Builds one random buffer into frame_q and span_q and picks its tag.
  function automatic void build_frame(output logic [7:0] tag);
    int          kind;
    int          size;
    int          cut;
    int          n;
    logic [7:0]  other;
    logic [15:0] nominal;
    kind = $urandom_range(0, 99);
    tag  = 8'($urandom);
    if ($urandom_range(0, 4) == 0) tag = tag | tlve_pkg::TagMultiMask;
    if (kind < 10) begin
      // Plain noise, sometimes searching for its own first byte.
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
      if ($urandom_range(0, 1)) tag = frame_q[0];
      size = frame_q.size();
      foreach (frame_q[i]) add_span(16'(size));
      if (size == 1 && $urandom_range(0, 1)) span_q[0] = '0;
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      do other = 8'($urandom); while (other == tag);
      append_element(other, draw_size());
    end
    // Buffers of kind 10 to 17 carry no matching element at all.
    if (kind >= 18) begin
      if ($urandom_range(0, 11) == 0) n = 0;
      else if ($urandom_range(0, 29) == 0) n = $urandom_range(128, 300);
      else n = $urandom_range(1, 8);
      append_element(tag, n);
    end
    repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
    if (frame_q.size() == 0) add_byte(8'($urandom));
    size = frame_q.size();
    foreach (frame_q[i]) add_span(16'(size));
    if (kind >= 80 && kind < 90) begin
      // Truncated buffer: the declared length ends somewhere inside the data.
      cut = $urandom_range(1, size);
      while (frame_q.size() > cut) begin
        void'(frame_q.pop_back());
        void'(span_q.pop_back());
      end
      foreach (span_q[i]) span_q[i] = 16'(cut);
    end else if (kind >= 90) begin
      // The length starts out large and drops on the last byte sent, which
      // ends the buffer early, possibly in the middle of the value.
      cut     = $urandom_range(0, size - 1);
      nominal = 16'($urandom_range(size, 65535));
      while (frame_q.size() > cut + 1) begin
        void'(frame_q.pop_back());
        void'(span_q.pop_back());
      end
      foreach (span_q[i]) span_q[i] = nominal;
      span_q[cut] = 16'($urandom_range(0, cut + 1));
    end
  endfunction

  initial begin
    logic [7:0] tag;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // A zero buffer length makes the byte a buffer of its own: not found.
    put(8'hFF, 16'h0000);
    play_frame(8'h00);

    // Short-form match of two value bytes, ending with the final status.
    put(8'h5A, 16'd4); put(8'h02, 16'd4); put(8'h00, 16'd4); put(8'hFF, 16'd4);
    play_frame(8'h5A);

    // Multi-byte tag is skipped, then the reserved length byte stops the scan.
    put(8'h9F, 16'd4); put(8'h80, 16'd4); put(8'h01, 16'd4); put(8'h80, 16'd4);
    play_frame(8'hFF);

    // Three-byte length that cannot fit: not found on the last length byte,
    // and the trailing byte is ignored.
    put(8'hC0, 16'd6); put(8'h83, 16'd6); put(8'hFF, 16'd6);
    put(8'hFF, 16'd6); put(8'hFF, 16'd6); put(8'h00, 16'd6);
    play_frame(8'hC0);

    // A matching element of length zero counts as not found.
    put(8'h01, 16'd3); put(8'h00, 16'd3); put(8'h55, 16'd3);
    play_frame(8'h01);

    // The buffer runs out right after an empty foreign element.
    put(8'h10, 16'd2); put(8'h00, 16'd2);
    play_frame(8'h20);

    // Buffer length drops from the maximum while value bytes are still owed:
    // the last value byte comes with a plain value status and last set.
    put(8'h7E, 16'hFFFF); put(8'h82, 16'hFFFF); put(8'h00, 16'hFFFF);
    put(8'h03, 16'hFFFF); put(8'hAA, 16'hFFFF); put(8'hBB, 16'd6);
    play_frame(8'h7E);

    wait_for_results();

    words_sent = 0;
    while (words_sent < RandomWords) begin
      sender_quiet = ($urandom_range(0, 3) == 0);
      build_frame(tag);
      play_frame(tag);
      if ($urandom_range(0, 49) == 0) wait_for_results();
    end

    // Drain, then give the queue and output register time to show any stray result.
    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
